FILE: rtl/lcdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdu_pkg
// Shared types, codes and constants for the Luhn check digit unit.
// ----------------------------------------------------------------------------
package lcdu_pkg;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_VERIFY = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned DIGIT_W = 4;

	// floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
	localparam logic [DATA_W-1:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int unsigned       RECIP10_SHIFT = 35;

	localparam logic [DATA_W-1:0]  ALL_ONES = {DATA_W{1'b1}};
	localparam logic [DIGIT_W-1:0] TEN      = 4'd10;
	localparam logic [DIGIT_W:0]   NINE_W   = 5'd9;
	localparam logic [DIGIT_W:0]   TEN_W    = 5'd10;

	typedef struct packed {
		logic [1:0]         mode;
		logic [DATA_W-1:0]  payload;   // payload being protected or checked
		logic [DATA_W-1:0]  rest;      // digits not yet taken
		logic [DIGIT_W-1:0] last_dig;  // received check digit
		logic               pay_ok;    // payload in range
		logic [DIGIT_W-1:0] sum;       // digit sum mod 10
	} lcdu_word_t;

	// 10^n - 1 for n up to 9, elaboration only
	function automatic logic [DATA_W-1:0] max_payload(input int unsigned n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < 9; i++) begin
			if (i < n) begin
				p = p * 64'd10;
			end
		end
		return p[DATA_W-1:0] - 32'd1;
	endfunction

	// x / 10 by reciprocal multiply
	function automatic logic [DATA_W-1:0] div10(input logic [DATA_W-1:0] x);
		logic [2*DATA_W-1:0] prod;
		prod = {{DATA_W{1'b0}}, x} * {{DATA_W{1'b0}}, RECIP10};
		return DATA_W'(prod >> RECIP10_SHIFT);
	endfunction

	function automatic logic [DATA_W-1:0] times10(input logic [DATA_W-1:0] x);
		return (x << 3) + (x << 1);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lcdu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdu_front
// Input stages: splits off the received check digit and range-checks the payload.
// ----------------------------------------------------------------------------
module lcdu_front #(
	parameter logic [31:0] MAX_PAY = 32'd99999999
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_vld,
	input  wire logic [1:0]               mode,
	input  wire logic [31:0]              value_in,
	output      logic                     out_vld,
	output      lcdu_pkg::lcdu_word_t     out_word
);
	import lcdu_pkg::*;

	logic              vld_s1;
	logic [1:0]        mode_s1;
	logic [DATA_W-1:0] val_s1;
	logic [DATA_W-1:0] quo_s1;

	logic              vld_s2;
	lcdu_word_t        word_s2;

	logic [DATA_W-1:0] pay;
	logic [DATA_W-1:0] rem_full;
	lcdu_word_t        word_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		val_s1  <= value_in;
		quo_s1  <= div10(value_in);
		word_s2 <= word_n;
	end

	always_comb begin
		pay      = (mode_s1 == MODE_ADD) ? val_s1 : quo_s1;
		rem_full = val_s1 - times10(quo_s1);
		word_n.mode     = mode_s1;
		word_n.payload  = pay;
		word_n.rest     = pay;
		word_n.last_dig = rem_full[DIGIT_W-1:0];
		word_n.pay_ok   = (pay != '0) && (pay <= MAX_PAY);
		word_n.sum      = '0;
	end

	assign out_vld  = vld_s2;
	assign out_word = word_s2;

endmodule
`default_nettype wire

FILE: rtl/lcdu_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdu_digit
// One pipeline stage: takes the next decimal digit and folds it into the sum.
// ----------------------------------------------------------------------------
module lcdu_digit #(
	parameter bit DOUBLE = 1'b1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire lcdu_pkg::lcdu_word_t in_word,
	output      logic                 out_vld,
	output      lcdu_pkg::lcdu_word_t out_word
);
	import lcdu_pkg::*;

	logic              vld_s1;
	lcdu_word_t        word_s1;

	logic [DATA_W-1:0] quo;
	logic [DATA_W-1:0] diff;
	logic [DIGIT_W:0]  dig;
	logic [DIGIT_W:0]  acc;
	lcdu_word_t        word_n;

	always_comb begin
		quo  = div10(in_word.rest);
		diff = in_word.rest - times10(quo);
		dig  = {1'b0, diff[DIGIT_W-1:0]};
		if (DOUBLE) begin
			dig = {diff[DIGIT_W-1:0], 1'b0};
			if (dig > NINE_W) begin
				dig = dig - NINE_W;
			end
		end
		acc = {1'b0, in_word.sum} + dig;
		if (acc >= TEN_W) begin
			acc = acc - TEN_W;
		end
		word_n      = in_word;
		word_n.rest = quo;
		word_n.sum  = acc[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= word_n;
	end

	assign out_vld  = vld_s1;
	assign out_word = word_s1;

endmodule
`default_nettype wire

FILE: rtl/lcdu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdu_back
// Output stage: forms the check digit and the result word for each mode.
// ----------------------------------------------------------------------------
module lcdu_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire lcdu_pkg::lcdu_word_t in_word,
	output      logic                 done,
	output      logic [31:0]          value_out,
	output      logic                 ok
);
	import lcdu_pkg::*;

	logic                done_q;
	logic [DATA_W-1:0]   value_q;
	logic                ok_q;

	logic [DIGIT_W-1:0]  chk;
	logic [DATA_W+3:0]   wide;
	logic [DATA_W-1:0]   value_n;
	logic                ok_n;

	always_comb begin
		chk  = (in_word.sum == '0) ? '0 : TEN - in_word.sum;
		wide = ({4'b0, in_word.payload} << 3) + ({4'b0, in_word.payload} << 1)
			+ {{DATA_W{1'b0}}, chk};
		value_n = ALL_ONES;
		ok_n    = 1'b0;
		case (in_word.mode)
			MODE_ADD: begin
				if (in_word.pay_ok && (wide[DATA_W+3:DATA_W] == '0)) begin
					value_n = wide[DATA_W-1:0];
					ok_n    = 1'b1;
				end
			end
			MODE_VERIFY: begin
				value_n = '0;
				ok_n    = in_word.pay_ok && (in_word.last_dig == chk);
			end
			MODE_REMOVE: begin
				if (in_word.pay_ok && (in_word.last_dig == chk)) begin
					value_n = in_word.payload;
					ok_n    = 1'b1;
				end
			end
			default: begin
				value_n = ALL_ONES;
				ok_n    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_n;
		ok_q    <= ok_n;
	end

	assign done      = done_q;
	assign value_out = value_q;
	assign ok        = ok_q;

endmodule
`default_nettype wire

FILE: rtl/luhn_check_digit_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// luhn_check_digit_unit_top
// Luhn mod-10 check digit: add, verify, or verify and strip.
// ----------------------------------------------------------------------------
// A word is taken on every cycle with start high; busy is always low. Each
// result passes through two input stages, one stage per payload digit and one
// output stage, and then appears with done high for one cycle. The receiver
// cannot stall, so results must be taken when done is high.
module luhn_check_digit_unit_top #(
	parameter int unsigned PAYLOAD_DIGITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] value_in,
	output      logic        done,
	output      logic [31:0] value_out,
	output      logic        ok
);
	import lcdu_pkg::*;

	localparam logic [DATA_W-1:0] MAX_PAY = max_payload(PAYLOAD_DIGITS);
	localparam int unsigned       LAT     = PAYLOAD_DIGITS + 3;

	logic       vld   [PAYLOAD_DIGITS+1];
	lcdu_word_t word  [PAYLOAD_DIGITS+1];

	assign busy = 1'b0;

	lcdu_front #(
		.MAX_PAY (MAX_PAY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.mode     (mode),
		.value_in (value_in),
		.out_vld  (vld[0]),
		.out_word (word[0])
	);

	for (genvar g = 0; g < PAYLOAD_DIGITS; g++) begin : g_dig
		lcdu_digit #(
			.DOUBLE ((g % 2) == 0)
		) u_digit (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[g]),
			.in_word  (word[g]),
			.out_vld  (vld[g+1]),
			.out_word (word[g+1])
		);
	end

	lcdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld[PAYLOAD_DIGITS]),
		.in_word   (word[PAYLOAD_DIGITS]),
		.done      (done),
		.value_out (value_out),
		.ok        (ok)
	);

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted word did not complete on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without accepted word");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((value_out == ALL_ONES) || (value_out == '0)))
		else $error("failed result carries a data value");
`endif

endmodule
`default_nettype wire

FILE: sim/luhn_check_digit_unit_top_tb.sv
// ----------------------------------------------------------------------------
// luhn_check_digit_unit_top_tb
// Self-checking bench for the Luhn mod-10 check digit unit.
// ----------------------------------------------------------------------------
// A directed set of words covers range limits, every mode and the error
// paths. A random set follows, mostly well-formed numbers with a valid or a
// corrupted check digit. Every accepted word is predicted in the bench. Each
// result marked by done is compared in order against the prediction.
// ----------------------------------------------------------------------------
module luhn_check_digit_unit_top_tb;
	import lcdu_pkg::*;

	localparam int unsigned PAYLOAD_DIGITS = 8;
	localparam int unsigned RANDOM_WORDS   = 1600;
	localparam int unsigned CYCLE_LIMIT    = 60000;
	localparam int unsigned DRAIN_CYCLES   = PAYLOAD_DIGITS + 10;
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [DATA_W-1:0] value;
	} luhn_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              ok;
	} luhn_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic [1:0]        mode     = MODE_ADD;
	logic [DATA_W-1:0] value_in = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] value_out;
	logic              ok;

	luhn_word_t   words_pending[$];
	luhn_result_t results_awaited[$];
	luhn_word_t   next_word;
	luhn_result_t head_result;
	int unsigned  words_sent = 0;
	int unsigned  cycles     = 0;
	int unsigned  failures   = 0;

	luhn_check_digit_unit_top #(
		.PAYLOAD_DIGITS(PAYLOAD_DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value_in(value_in),
		.done(done),
		.value_out(value_out),
		.ok(ok)
	);

	function automatic logic [63:0] pow10(input int unsigned n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	function automatic bit payload_in_range(input logic [63:0] payload);
		return payload >= 64'd1 && payload < pow10(PAYLOAD_DIGITS);
	endfunction

	// doubled digits at even positions, plain digits at odd ones
	function automatic logic [3:0] luhn_digit(input logic [63:0] payload);
		logic [63:0] rest;
		int unsigned dig;
		int unsigned acc;
		rest = payload;
		acc  = 0;
		for (int pos = 0; pos < PAYLOAD_DIGITS; pos++) begin
			dig  = int'(rest % 64'd10);
			rest = rest / 64'd10;
			if (pos % 2 == 0) begin
				dig = dig * 2;
				if (dig > 9) begin
					dig = dig - 9;
				end
			end
			acc = acc + dig;
		end
		return 4'((acc * 9) % 10);
	endfunction

	function automatic bit luhn_valid(input logic [63:0] number);
		if (!payload_in_range(number / 64'd10)) begin
			return 1'b0;
		end
		return (number % 64'd10) == 64'(luhn_digit(number / 64'd10));
	endfunction

	function automatic luhn_result_t luhn_predict(input logic [1:0] m,
		input logic [DATA_W-1:0] v);
		luhn_result_t r;
		logic [63:0]  wide;
		r.value = ALL_ONES;
		r.ok    = 1'b0;
		case (m)
			MODE_ADD: begin
				if (payload_in_range(64'(v))) begin
					wide = 64'(v) * 64'd10 + 64'(luhn_digit(64'(v)));
					if (wide <= 64'(ALL_ONES)) begin
						r.value = wide[DATA_W-1:0];
						r.ok    = 1'b1;
					end
				end
			end
			MODE_VERIFY: begin
				r.value = '0;
				r.ok    = luhn_valid(64'(v));
			end
			MODE_REMOVE: begin
				if (luhn_valid(64'(v))) begin
					r.value = v / 32'd10;
					r.ok    = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] random_payload();
		int unsigned n;
		if ($urandom_range(9) == 0) begin
			return ($urandom_range(1)) ? 32'd1 : DATA_W'(pow10(PAYLOAD_DIGITS) - 1);
		end
		n = $urandom_range(1, PAYLOAD_DIGITS);
		return DATA_W'($urandom_range(int'(pow10(n) - 1), int'(pow10(n - 1))));
	endfunction

	function automatic logic [DATA_W-1:0] protect(input logic [DATA_W-1:0] payload,
		input int unsigned skew);
		return payload * 32'd10 + DATA_W'((luhn_digit(64'(payload)) + skew) % 10);
	endfunction

	task automatic queue_word(input logic [1:0] m, input logic [DATA_W-1:0] v);
		words_pending.push_back('{mode: m, value: v});
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("luhn_check_digit_unit_top test failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				results_awaited.push_back(luhn_predict(mode, value_in));
				words_sent = words_sent + 1;
			end
			if (!start || !busy) begin
				if (words_pending.size() != 0 &&
					((words_sent >= 700 && words_sent < 1000) || $urandom_range(99) >= 24)) begin
					next_word = words_pending.pop_front();
					start    <= 1'b1;
					mode     <= next_word.mode;
					value_in <= next_word.value;
				end else begin
					start    <= 1'b0;
					mode     <= 2'($urandom);
					value_in <= $urandom;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_awaited.size() == 0) begin
				$error("unexpected result: value_out %0d ok %0b", value_out, ok);
				failures = failures + 1;
			end else begin
				head_result = results_awaited.pop_front();
				if (value_out !== head_result.value) begin
					$error("value_out: expected %0d, got %0d", head_result.value, value_out);
					failures = failures + 1;
				end
				if (ok !== head_result.ok) begin
					$error("ok: expected %0b, got %0b", head_result.ok, ok);
					failures = failures + 1;
				end
			end
		end
	end

	initial begin
		int unsigned sel;
		int unsigned kind;
		logic [1:0]  m;
		logic [DATA_W-1:0] v;

		queue_word(MODE_ADD, 32'd1);
		queue_word(MODE_ADD, 32'd99999999);
		queue_word(MODE_ADD, 32'd0);
		queue_word(MODE_ADD, 32'd100000000);
		queue_word(MODE_ADD, ALL_ONES);
		queue_word(MODE_ADD, 32'd12345678);
		queue_word(MODE_VERIFY, protect(32'd1, 0));
		queue_word(MODE_VERIFY, protect(32'd1, 3));
		queue_word(MODE_VERIFY, 32'd0);
		queue_word(MODE_VERIFY, 32'd9);
		queue_word(MODE_VERIFY, protect(32'd99999999, 0));
		queue_word(MODE_VERIFY, 32'd1000000000);
		queue_word(MODE_VERIFY, ALL_ONES);
		queue_word(MODE_REMOVE, protect(32'd1, 0));
		queue_word(MODE_REMOVE, protect(32'd1, 1));
		queue_word(MODE_REMOVE, 32'd5);
		queue_word(MODE_REMOVE, protect(32'd99999999, 0));
		queue_word(MODE_REMOVE, protect(32'd99999999, 9));
		queue_word(MODE_REMOVE, 32'd1000000008);
		queue_word(MODE_REMOVE, ALL_ONES);
		queue_word(MODE_UNUSED, 32'd0);
		queue_word(MODE_UNUSED, protect(32'd4242, 0));
		queue_word(MODE_UNUSED, ALL_ONES);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			sel  = $urandom_range(99);
			kind = $urandom_range(99);
			if (sel < 35) begin
				m = MODE_ADD;
			end else if (sel < 65) begin
				m = MODE_VERIFY;
			end else if (sel < 95) begin
				m = MODE_REMOVE;
			end else begin
				m = MODE_UNUSED;
			end
			if (m == MODE_ADD) begin
				if (kind < 80) begin
					v = random_payload();
				end else if (kind < 92) begin
					v = $urandom;
				end else begin
					v = ($urandom_range(1)) ? 32'd0 : DATA_W'(pow10(PAYLOAD_DIGITS));
				end
			end else if (m == MODE_UNUSED || kind >= 80) begin
				v = $urandom;
			end else if (kind < 60) begin
				v = protect(random_payload(), 0);
			end else begin
				v = protect(random_payload(), $urandom_range(1, 9));
			end
			queue_word(m, v);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (words_pending.size() != 0 || start || results_awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("luhn_check_digit_unit_top test passed");
		end else begin
			$display("luhn_check_digit_unit_top test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/lcdu_pkg.sv
rtl/lcdu_front.sv
rtl/lcdu_digit.sv
rtl/lcdu_back.sv
rtl/luhn_check_digit_unit_top.sv
sim/luhn_check_digit_unit_top_tb.sv
